[rtl/modexp_pkg.sv]
// Package for the modular exponentiation block: widths, status codes and types.
// Depends on nothing.
package modexp_pkg;
    localparam int WORD_BITS = 64;
    localparam int CNT_BITS  = $clog2(WORD_BITS + 1);

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO_MOD = 2'd1;
    localparam logic [1:0] ST_NEG_EXP  = 2'd2;

    typedef logic [WORD_BITS-1:0] t_word;

    typedef struct packed {
        logic  start;
        t_word a;
        t_word b;
        t_word modulus;
    } t_mul_req;

    typedef struct packed {
        logic  done;
        t_word product;
    } t_mul_rsp;

    typedef struct packed {
        t_word base_value;
        t_word exponent_value;
        t_word modulus_value;
    } t_in_beat;

    typedef struct packed {
        t_word      power_residue;
        logic [1:0] status_code;
    } t_out_beat;
endpackage

[rtl/modexp_if.sv]
// Valid/ready channel interface carrying one payload beat.
// Depends on nothing.
interface modexp_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[rtl/modexp_mulmod.sv]
// Shift-add-subtract modular multiplier, one multiplier bit per cycle.
// Depends on modexp_pkg.
module modexp_mulmod (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  modexp_pkg::t_mul_req i_req,
    output modexp_pkg::t_mul_rsp o_rsp
);
    import modexp_pkg::*;

    logic                r_busy, n_busy;
    logic                r_done, n_done;
    logic [CNT_BITS-1:0] r_cnt, n_cnt;
    t_word               r_a, n_a, r_b, n_b, r_mod, n_mod, r_acc, n_acc;
    logic [WORD_BITS:0]  w_dbl, w_dbl_red, w_sum;
    t_word               w_step;

    always_comb begin
        w_dbl     = {r_acc, 1'b0};
        w_dbl_red = (w_dbl >= {1'b0, r_mod}) ? w_dbl - {1'b0, r_mod} : w_dbl;
        w_sum     = w_dbl_red + {1'b0, r_a};
        if (r_b[WORD_BITS-1]) begin
            w_step = (w_sum >= {1'b0, r_mod}) ? WORD_BITS'(w_sum - {1'b0, r_mod})
                                              : WORD_BITS'(w_sum);
        end else begin
            w_step = WORD_BITS'(w_dbl_red);
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_a    = r_a;
        n_b    = r_b;
        n_mod  = r_mod;
        n_acc  = r_acc;
        if (i_req.start && !r_busy) begin
            n_busy = 1'b1;
            n_cnt  = CNT_BITS'(WORD_BITS);
            n_a    = i_req.a;
            n_b    = i_req.b;
            n_mod  = i_req.modulus;
            n_acc  = '0;
        end else if (r_busy) begin
            n_acc = w_step;
            n_b   = {r_b[WORD_BITS-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CNT_BITS'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_mod <= n_mod;
        r_acc <= n_acc;
    end

    assign o_rsp.done    = r_done;
    assign o_rsp.product = r_acc;
endmodule

[rtl/modexp_divrem.sv]
// Restoring remainder unit, one dividend bit per cycle.
// Depends on modexp_pkg.
module modexp_divrem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  modexp_pkg::t_word    i_dividend,
    input  modexp_pkg::t_word    i_divisor,
    output logic                 o_done,
    output modexp_pkg::t_word    o_rem
);
    import modexp_pkg::*;

    logic                r_busy, r_done;
    logic [CNT_BITS-1:0] r_cnt;
    t_word               r_num, r_div, r_rem;
    logic [WORD_BITS:0]  w_sh;
    t_word               w_next;

    always_comb begin
        w_sh   = {r_rem, r_num[WORD_BITS-1]};
        w_next = (w_sh >= {1'b0, r_div}) ? WORD_BITS'(w_sh - {1'b0, r_div})
                                         : WORD_BITS'(w_sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_BITS'(WORD_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
        if (i_start && !r_busy) begin
            r_num <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[WORD_BITS-2:0], 1'b0};
            r_rem <= w_next;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

[rtl/modular_exponentiation.sv]
// Modular exponentiation, right-to-left square and multiply on a shared
// shift-add-subtract modular multiplier, after a reduction of the base by a
// restoring remainder unit; up to 125 multiplications (63 multiplies, 62
// squarings). Error and unit-modulus beats go straight to the output. One item
// at a time; ready is high only when idle. The result is held in an output
// register until taken. Sync active-low reset.
module modular_exponentiation (
    input  logic     i_clk,
    input  logic     i_rst_n,
    modexp_if.sink   i_in,
    modexp_if.source o_out
);
    import modexp_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RED  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_SQR  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0] r_state;
    logic       r_wait;
    logic       r_bneg, r_mneg;
    t_word      r_base, r_exp, r_mod, r_acc, r_bmag;
    t_word      r_res;
    logic [1:0] r_st;

    t_mul_req   w_req;
    t_mul_rsp   w_rsp;
    logic       w_div_start, w_div_done;
    t_word      w_rem;
    t_word      w_b, w_e, w_m, w_mmag;

    assign w_b    = i_in.data.base_value;
    assign w_e    = i_in.data.exponent_value;
    assign w_m    = i_in.data.modulus_value;
    assign w_mmag = w_m[WORD_BITS-1] ? t_word'(-w_m) : w_m;

    modexp_divrem u_divrem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_bmag),
        .i_divisor  (r_mod),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    modexp_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    assign w_div_start   = (r_state == S_RED) && !r_wait;
    assign w_req.start   = (r_state == S_MUL || r_state == S_SQR) && !r_wait;
    assign w_req.a       = (r_state == S_MUL) ? r_acc : r_base;
    assign w_req.b       = r_base;
    assign w_req.modulus = r_mod;

    assign i_in.ready              = (r_state == S_IDLE);
    assign o_out.valid             = (r_state == S_OUT);
    assign o_out.data.power_residue = r_res;
    assign o_out.data.status_code   = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_bneg <= w_b[WORD_BITS-1];
                        r_mneg <= w_m[WORD_BITS-1];
                        r_bmag <= w_b[WORD_BITS-1] ? t_word'(-w_b) : w_b;
                        r_exp  <= w_e;
                        r_mod  <= w_mmag;
                        r_acc  <= t_word'(1);
                        r_res  <= '0;
                        r_wait <= 1'b0;
                        if (w_e[WORD_BITS-1]) begin
                            r_st    <= ST_NEG_EXP;
                            r_state <= S_OUT;
                        end else if (w_m == '0) begin
                            r_st    <= ST_ZERO_MOD;
                            r_state <= S_OUT;
                        end else if (w_mmag == t_word'(1)) begin
                            r_st    <= ST_OK;
                            r_state <= S_OUT;
                        end else begin
                            r_st    <= ST_OK;
                            r_state <= S_RED;
                        end
                    end
                end
                S_RED: begin
                    r_wait <= 1'b1;
                    if (w_div_done) begin
                        r_wait <= 1'b0;
                        r_base <= (r_bneg && w_rem != '0) ? r_mod - w_rem : w_rem;
                        r_state <= r_exp[0] ? S_MUL :
                                   (r_exp == '0 ? S_FIN : S_SQR);
                    end
                end
                S_MUL: begin
                    r_wait <= 1'b1;
                    if (w_rsp.done) begin
                        r_wait <= 1'b0;
                        r_acc  <= w_rsp.product;
                        r_state <= (r_exp <= t_word'(1)) ? S_FIN : S_SQR;
                    end
                end
                S_SQR: begin
                    r_wait <= 1'b1;
                    if (w_rsp.done) begin
                        r_wait  <= 1'b0;
                        r_base  <= w_rsp.product;
                        r_exp   <= r_exp >> 1;
                        r_state <= r_exp[1] ? S_MUL :
                                   ((r_exp >> 1) <= t_word'(1) ? S_FIN : S_SQR);
                    end
                end
                S_FIN: begin
                    r_res   <= (r_mneg && r_acc != '0) ? r_acc - r_mod : r_acc;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (o_out.ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/modexp_checker.sv]
// Port-level checker for the modular exponentiation block, bound to the top.
// Depends on modexp_pkg and modexp_if.
module modexp_checker (
    input logic      i_clk,
    input logic      i_rst_n,
    modexp_if.sink   i_in,
    modexp_if.source o_out
);
    import modexp_pkg::*;

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in.ready && o_out.valid)) else $error("ready while result pending");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.ready |=> o_out.valid && $stable(o_out.data))
        else $error("result beat dropped");
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.data.status_code != ST_OK |->
        o_out.data.power_residue == '0) else $error("residue on error");
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.data.status_code <= ST_NEG_EXP) else $error("bad status");
endmodule

bind modular_exponentiation modexp_checker u_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_in    (i_in),
    .o_out   (o_out)
);

[dv/tb_top.sv]
// Testbench for modular_exponentiation: random and directed base, exponent
// and modulus beats checked against a square-and-multiply predictor.
// Depends on modexp_pkg, modexp_if and the modular_exponentiation RTL.
module tb_top;
    import modexp_pkg::*;

    localparam int LIMIT_CYCLES = 4000000;
    localparam int N_RANDOM     = 100;

    logic i_clk;
    logic i_rst_n;

    modexp_if #(.t_payload(t_in_beat))  in_ch ();
    modexp_if #(.t_payload(t_out_beat)) out_ch ();

    modular_exponentiation dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    t_in_beat  pending_beats[$];
    t_out_beat expected_residues[$];
    int        idle_pct;
    int        stall_pct;
    bit        hold_off;
    int        n_errors;
    int        n_sent;
    int        n_checked;
    int        n_err_status;
    longint    cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic logic [63:0] mod_product(logic [63:0] a, logic [63:0] b,
                                                logic [63:0] m);
        logic [64:0] acc;
        acc = '0;
        for (int i = 63; i >= 0; i--) begin
            acc = acc << 1;
            if (acc >= m) acc = acc - m;
            if (b[i]) begin
                acc = acc + a;
                if (acc >= m) acc = acc - m;
            end
        end
        return acc[63:0];
    endfunction

    function automatic t_out_beat predict_power(t_in_beat beat);
        t_out_beat   res;
        logic [63:0] e;
        logic [63:0] m;
        logic [63:0] mag;
        logic [63:0] b;
        logic [63:0] acc;
        e   = beat.exponent_value;
        m   = beat.modulus_value;
        res = '{power_residue: '0, status_code: ST_OK};
        if (e[63]) begin
            res.status_code = ST_NEG_EXP;
            return res;
        end
        if (m == 0) begin
            res.status_code = ST_ZERO_MOD;
            return res;
        end
        mag = m[63] ? -m : m;
        if (mag == 1) return res;
        b = beat.base_value[63] ? -beat.base_value : beat.base_value;
        b = b % mag;
        if (beat.base_value[63] && b != 0) b = mag - b;
        acc = 1;
        for (int i = 0; i < 64; i++) begin
            if (e[i]) acc = mod_product(acc, b, mag);
            if ((e >> i) <= 1) break;
            b = mod_product(b, b, mag);
        end
        if (m[63] && acc != 0) acc = acc - mag;
        res.power_residue = acc;
        return res;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic logic [63:0] rand_small(int hi);
        logic [63:0] v;
        v = 64'($urandom_range(hi, 0));
        return $urandom_range(1, 0) ? -v : v;
    endfunction

    task automatic queue_beat(logic [63:0] b, logic [63:0] e, logic [63:0] m);
        pending_beats.push_back('{base_value: b, exponent_value: e, modulus_value: m});
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) begin
                expected_residues.push_back(predict_power(in_ch.data));
                n_sent++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_beats.size() != 0 && !hold_off
                        && $urandom_range(99, 0) >= idle_pct) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pending_beats.pop_front();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_residues.size() == 0) begin
                    $error("result beat with nothing expected");
                    n_errors++;
                end else begin
                    want = expected_residues.pop_front();
                    if (out_ch.data.power_residue !== want.power_residue) begin
                        $error("power_residue expected %h actual %h",
                               want.power_residue, out_ch.data.power_residue);
                        n_errors++;
                    end
                    if (out_ch.data.status_code !== want.status_code) begin
                        $error("status_code expected %0d actual %0d",
                               want.status_code, out_ch.data.status_code);
                        n_errors++;
                    end
                    if (want.status_code != ST_OK) n_err_status++;
                    n_checked++;
                end
            end
            out_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic drain();
        while (pending_beats.size() != 0 || in_ch.valid
               || expected_residues.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int idle, int stall, int count);
        logic [63:0] m;
        idle_pct  = idle;
        stall_pct = stall;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(9, 0))
                0: queue_beat(rand_word(), rand_word(), rand_word());
                1: queue_beat(rand_word(), -rand_small(1000) - 1, rand_word());
                2: queue_beat(rand_word(), rand_small(20), 0);
                3: queue_beat(rand_small(50), 64'($urandom_range(30, 0)), rand_small(100));
                default: begin
                    m = rand_word();
                    if ($urandom_range(3, 0) == 0) m = m >> $urandom_range(60, 1);
                    if (m == 0) m = 7;
                    queue_beat(rand_word(), (rand_word() >> $urandom_range(62, 0))
                               & 64'h7fff_ffff_ffff_ffff, m);
                end
            endcase
        end
        drain();
    endtask

    initial begin
        n_errors = 0; n_sent = 0; n_checked = 0; n_err_status = 0;
        cycle_count = 0; hold_off = 0;
        idle_pct = 0; stall_pct = 0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_beat(5, 3, 13);
        queue_beat(-5, 3, 13);
        queue_beat(5, 3, -13);
        queue_beat(-5, 3, -13);
        queue_beat(7, -1, 13);
        queue_beat(7, -1, 0);
        queue_beat(7, 5, 0);
        queue_beat(123, 77, 1);
        queue_beat(123, 77, -1);
        queue_beat(123, 0, 97);
        queue_beat(123, 0, -97);
        queue_beat(64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000);
        queue_beat(64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff);
        queue_beat(-1, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffe7);
        queue_beat(-1, 64'h7fff_ffff_ffff_fffe, 64'h8000_0000_0000_0001);
        queue_beat(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 5);
        queue_beat(0, 0, 2);
        queue_beat(0, 9, -2);
        queue_beat(64'hffff_ffff_ffff_ffff, 64'h5555_5555_5555_5555, 64'hffff_ffff_ffff_fffd);
        queue_beat(64'haaaa_aaaa_aaaa_aaaa, 64'h2aaa_aaaa_aaaa_aaab, 64'h5555_5555_5555_5555);
        idle_pct = 0; stall_pct = 0;
        drain();

        hold_off = 1;
        queue_beat(3, 200, 1000003);
        repeat (20) @(posedge i_clk);
        hold_off = 0;
        drain();

        run_phase(0, 0, 20);
        run_phase(58, 0, 20);
        run_phase(0, 58, 20);
        run_phase(33, 33, 20);
        repeat (200) @(posedge i_clk);

        $display("covered %0d beats, %0d results checked, %0d with error status",
                 n_sent, n_checked, n_err_status);
        if (n_errors == 0 && expected_residues.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
